// ----- src/bklex_pkg.sv -----
// shared types and character codes for the keyword lexer
// no dependencies; every other lexer file but the queue imports this package
`default_nettype none

package bklex_pkg;

    // default configuration of the top level
    localparam int BKL_INT_WIDTH   = 16;
    localparam int BKL_LINE_LEN    = 256;
    localparam int BKL_QUEUE_DEPTH = 2;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // character class decided by the front end
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_KW_LETTER,
        CLS_LETTER,
        CLS_OP,
        CLS_LT,
        CLS_GT,
        CLS_OTHER
    } t_cls;

    // one classified character as it crosses the queue
    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
        logic       eol;
    } t_item;

    typedef enum logic [3:0] {
        KIND_ERROR,
        KIND_INT,
        KIND_VAR,
        KIND_OP,
        KIND_END,
        KIND_GOTO,
        KIND_GOSUB,
        KIND_IF,
        KIND_LET,
        KIND_REM,
        KIND_RETURN,
        KIND_THEN,
        KIND_LE,
        KIND_NE,
        KIND_GE
    } t_kind;

    // one token as produced by the back end
    typedef struct packed {
        logic [7:0]  col;
        logic        ovf;
        logic [15:0] value;
        logic [7:0]  ch;
        t_kind       kind;
    } t_token;

endpackage

`default_nettype wire

// ----- src/basic_keyword_lexer_unit.sv -----
// top level of the keyword lexer: front end, queue and token back end
// depends on bklex_pkg, bklex_front, bklex_queue and bklex_back
`default_nettype none

// Streaming lexer for a small BASIC dialect. One byte of a source line comes in per request
// on the slave side, with tlast on the last byte of the line; tokens leave on the master side,
// tlast marking the final token of a line (a line whose last byte closes no token marks none).
// Spaces and tabs are skipped; decimal integers saturate at 2^INT_WIDTH-1 and set the overflow
// bit; single upper-case letters are variables; END GOTO GOSUB IF LET REM RETURN THEN are
// keywords; + - * / ( ) = , and newline are operators; <= <> >= >< are compound operators; any
// other byte is an error token carrying the byte and its column. Letters that may still start
// a keyword are held and rescanned as variables when the keyword fails. The front end
// classifies each byte and counts columns (modulo LINE_LEN) into a two-entry queue, so input
// keeps flowing while the back end works. The back end sequencer takes one action per step:
// a byte with nothing pending, or one that extends an integer or completes <= <> >= ><, is
// handled directly; a byte after an integer first emits the integer; a byte after a lone <
// or > that does not pair with it first emits that operator; a letter after held letters
// joins them and is resolved, rescanning letters as variables (up to six); any other byte
// after held letters first resolves them all. An end-of-line byte adds a flush check and a
// tlast release, after flushing a pending integer, lone < or >, or held letters.
// A token waits in the output register; the back end runs on until it has another token to
// emit and then stalls until the register frees. On the last byte of a line one token is held
// back so that the final one can be marked with tlast.
module basic_keyword_lexer_unit #(
    parameter int INT_WIDTH = bklex_pkg::BKL_INT_WIDTH,
    parameter int LINE_LEN  = bklex_pkg::BKL_LINE_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // source characters
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // text_char
    input  wire logic        i_s_tlast,   // end_of_line
    // tokens
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // token_kind, token_char, int_value, int_overflow,
                                          // start_column, zero pad
    output logic             o_m_tlast    // last_of_line
);
    import bklex_pkg::*;

    localparam int COL_W = $clog2(LINE_LEN);
    localparam int QW    = $bits(t_item) + COL_W;

    // front end to queue
    logic             w_push;
    t_item            w_push_item;
    logic [COL_W-1:0] w_push_col;
    logic             w_full;

    // queue to back end
    logic             w_q_valid;
    logic [QW-1:0]    w_q_data;
    t_item            w_q_item;
    logic [COL_W-1:0] w_q_col;
    logic             w_q_pop;

    t_token           w_token;

    bklex_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .o_col      (w_push_col)
    );

    // classified characters wait here while the back end resolves tokens
    bklex_queue #(
        .WIDTH (QW),
        .DEPTH (BKL_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_col, w_push_item}),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    assign w_q_item = w_q_data[$bits(t_item)-1:0];
    assign w_q_col  = w_q_data[QW-1:$bits(t_item)];

    bklex_back #(
        .INT_WIDTH (INT_WIDTH),
        .LINE_LEN  (LINE_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .i_q_col    (w_q_col),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_token    (w_token),
        .o_m_tlast  (o_m_tlast)
    );

    // token fields from the lowest bit up
    assign o_m_tdata = {3'b000, w_token.col, w_token.ovf, w_token.value,
                        w_token.ch, w_token.kind};

endmodule

`default_nettype wire

// ----- src/bklex_queue.sv -----
// small register queue between the lexer front end and back end
// no package dependencies
`default_nettype none

module bklex_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/bklex_front.sv -----
// lexer front end: takes characters, classifies them and counts columns
// depends on bklex_pkg
`default_nettype none

module bklex_front #(
    parameter int LINE_LEN = bklex_pkg::BKL_LINE_LEN
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,
    input  wire logic                        i_s_tlast,
    input  wire logic                        i_full,
    output logic                             o_push,
    output bklex_pkg::t_item                 o_item,
    output logic [$clog2(LINE_LEN)-1:0]      o_col
);
    import bklex_pkg::*;

    localparam int COL_W = $clog2(LINE_LEN);

    logic [COL_W-1:0] r_col;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        case (c) inside
            CH_SPACE, CH_TAB:                      r = CLS_SPACE;
            ["0":"9"]:                             r = CLS_DIGIT;
            "E", "G", "I", "L", "R", "T":          r = CLS_KW_LETTER;
            ["A":"Z"]:                             r = CLS_LETTER;
            "+", "-", "*", "/", "(", ")", CH_EQ, ",", CH_LF: r = CLS_OP;
            CH_LT:                                 r = CLS_LT;
            CH_GT:                                 r = CLS_GT;
            default:                               r = CLS_OTHER;
        endcase
        return r;
    endfunction

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_item     = '{ch: i_s_tdata, cls: classify(i_s_tdata), eol: i_s_tlast};
    assign o_col      = r_col;

    // column restarts after the last byte of a line and wraps after LINE_LEN - 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (o_push) begin
            if (i_s_tlast || (r_col == COL_W'(LINE_LEN - 1))) begin
                r_col <= '0;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/bklex_back.sv -----
// lexer back end: token sequencer with keyword prefix hold and rescan
// depends on bklex_pkg
`default_nettype none

module bklex_back #(
    parameter int INT_WIDTH = bklex_pkg::BKL_INT_WIDTH,
    parameter int LINE_LEN  = bklex_pkg::BKL_LINE_LEN
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire bklex_pkg::t_item            i_q_item,
    input  wire logic [$clog2(LINE_LEN)-1:0] i_q_col,
    output logic                             o_q_pop,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output bklex_pkg::t_token                o_token,
    output logic                             o_m_tlast
);
    import bklex_pkg::*;

    localparam int COL_W    = $clog2(LINE_LEN);
    localparam int CW8      = (COL_W > 8) ? COL_W : 8;
    localparam int VW       = (INT_WIDTH > 16) ? INT_WIDTH : 16;
    localparam int HB_DEPTH = 6;
    localparam int KW_NUM   = 8;

    localparam logic [7:0] KW_TEXT [KW_NUM][HB_DEPTH] = '{
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00},
        '{"G", "O", "T", "O", 8'h00, 8'h00},
        '{"G", "O", "S", "U", "B", 8'h00},
        '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"L", "E", "T", 8'h00, 8'h00, 8'h00},
        '{"R", "E", "M", 8'h00, 8'h00, 8'h00},
        '{"R", "E", "T", "U", "R", "N"},
        '{"T", "H", "E", "N", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd3, 3'd6, 3'd4
    };

    typedef logic [HB_DEPTH-1:0][7:0] t_hbuf;

    typedef enum logic [2:0] {
        P_HANDLE,
        P_FRESH,
        P_RESOLVE,
        P_FLUSH,
        P_END
    } t_phase;

    typedef enum logic [1:0] {
        RET_FRESH,
        RET_HDONE,
        RET_FLUSH
    } t_ret;

    // keyword whose text equals the first n letters, else error kind
    function automatic t_kind kw_complete(input t_hbuf b, input logic [2:0] n);
        t_kind r;
        logic  eq;
        r = KIND_ERROR;
        for (int k = 0; k < KW_NUM; k++) begin
            eq = (KW_LEN[k] == n);
            for (int i = 0; i < HB_DEPTH; i++) begin
                if ((3'(i) < n) && (b[i] != KW_TEXT[k][i])) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                r = t_kind'(4'(KIND_END) + 4'(k));
            end
        end
        return r;
    endfunction

    // first n letters are a proper prefix of some keyword
    function automatic logic kw_prefix(input t_hbuf b, input logic [2:0] n);
        logic r;
        logic eq;
        r = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
            eq = (KW_LEN[k] > n);
            for (int i = 0; i < HB_DEPTH; i++) begin
                if ((3'(i) < n) && (b[i] != KW_TEXT[k][i])) begin
                    eq = 1'b0;
                end
            end
            r = r | eq;
        end
        return r;
    endfunction

    function automatic logic [7:0] col8(input logic [COL_W-1:0] c);
        logic [CW8-1:0] x;
        x = CW8'(c);
        return x[7:0];
    endfunction

    function automatic t_token mk_tok(input t_kind k, input logic [7:0] ch,
                                      input logic [COL_W-1:0] c);
        t_token t;
        t = '{kind: k, ch: ch, value: 16'h0000, ovf: 1'b0, col: col8(c)};
        return t;
    endfunction

    // step state
    t_phase               r_phase, n_phase;
    t_ret                 r_ret, n_ret;
    logic                 r_forced, n_forced;
    t_hbuf                r_hb, n_hb;
    logic [2:0]           r_hcnt, n_hcnt;
    logic                 r_hold_cmp, n_hold_cmp;
    logic [COL_W-1:0]     r_tstart, n_tstart;
    logic [INT_WIDTH-1:0] r_acc, n_acc;
    logic                 r_num_active, n_num_active;
    logic                 r_num_sat, n_num_sat;
    // token held back so the last one of a line can be marked
    logic                 r_pend_v, n_pend_v;
    t_token               r_pend, n_pend;
    // output register
    logic                 r_out_v, n_out_v;
    t_token               r_out, n_out;
    logic                 r_out_last, n_out_last;

    logic                 w_em;
    t_token               w_em_tok;
    logic                 w_pop;
    logic                 w_hdone;
    logic                 w_fresh;
    logic                 w_ret;
    logic                 w_stall;
    logic                 w_out_free;
    logic                 w_can_emit;
    logic                 w_eol;
    logic [7:0]           w_c;
    t_cls                 w_cls;
    t_kind                w_kw;
    logic                 w_kwp;
    logic [INT_WIDTH+3:0] w_mul;
    logic                 w_mul_ovf;
    logic [VW-1:0]        w_val;
    t_token               w_num_tok;
    logic [COL_W-1:0]     w_tstart_inc;

    assign w_c          = i_q_item.ch;
    assign w_cls        = i_q_item.cls;
    assign w_eol        = i_q_item.eol;
    assign w_kw         = kw_complete(r_hb, r_hcnt);
    assign w_kwp        = kw_prefix(r_hb, r_hcnt);
    assign w_mul        = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                        + (INT_WIDTH+4)'(w_c[3:0]);
    assign w_mul_ovf    = |w_mul[INT_WIDTH+3:INT_WIDTH];
    assign w_val        = VW'(r_acc);
    assign w_num_tok    = '{kind: KIND_INT, ch: 8'h00, value: w_val[15:0],
                            ovf: r_num_sat, col: col8(r_tstart)};
    assign w_tstart_inc = (r_tstart == COL_W'(LINE_LEN - 1)) ? '0 : r_tstart + 1'b1;
    assign w_out_free   = !r_out_v || i_m_tready;
    assign w_can_emit   = w_eol ? (!r_pend_v || w_out_free) : w_out_free;

    always_comb begin
        n_phase      = r_phase;
        n_ret        = r_ret;
        n_forced     = r_forced;
        n_hb         = r_hb;
        n_hcnt       = r_hcnt;
        n_hold_cmp   = r_hold_cmp;
        n_tstart     = r_tstart;
        n_acc        = r_acc;
        n_num_active = r_num_active;
        n_num_sat    = r_num_sat;
        w_em         = 1'b0;
        w_em_tok     = w_num_tok;
        w_pop        = 1'b0;
        w_hdone      = 1'b0;
        w_fresh      = 1'b0;
        w_ret        = 1'b0;

        unique case (r_phase)
            P_HANDLE: begin
                if (i_q_valid) begin
                    if (r_num_active) begin
                        if (w_cls == CLS_DIGIT) begin
                            n_acc     = w_mul_ovf ? '1 : w_mul[INT_WIDTH-1:0];
                            n_num_sat = r_num_sat | w_mul_ovf;
                            w_hdone   = 1'b1;
                        end else begin
                            w_em         = 1'b1;
                            w_em_tok     = w_num_tok;
                            n_num_active = 1'b0;
                            n_num_sat    = 1'b0;
                            n_acc        = '0;
                        end
                    end else if (r_hold_cmp) begin
                        n_hold_cmp = 1'b0;
                        w_em       = 1'b1;
                        if (w_c == CH_EQ) begin
                            w_em_tok = mk_tok((r_hb[0] == CH_LT) ? KIND_LE : KIND_GE,
                                              8'h00, r_tstart);
                            w_hdone  = 1'b1;
                        end else if (((r_hb[0] == CH_LT) && (w_cls == CLS_GT)) ||
                                     ((r_hb[0] == CH_GT) && (w_cls == CLS_LT))) begin
                            w_em_tok = mk_tok(KIND_NE, 8'h00, r_tstart);
                            w_hdone  = 1'b1;
                        end else begin
                            w_em_tok = mk_tok(KIND_OP, r_hb[0], r_tstart);
                            n_phase  = P_FRESH;
                        end
                    end else if (r_hcnt != 3'd0) begin
                        n_phase = P_RESOLVE;
                        if ((w_cls == CLS_KW_LETTER) || (w_cls == CLS_LETTER)) begin
                            n_hb[r_hcnt] = w_c;
                            n_hcnt       = r_hcnt + 3'd1;
                            n_forced     = 1'b0;
                            n_ret        = RET_HDONE;
                        end else begin
                            n_forced = 1'b1;
                            n_ret    = RET_FRESH;
                        end
                    end else begin
                        w_fresh = 1'b1;
                    end
                end
            end
            P_FRESH: begin
                w_fresh = 1'b1;
            end
            P_RESOLVE: begin
                if (r_hcnt == 3'd0) begin
                    w_ret = 1'b1;
                end else if (w_kw != KIND_ERROR) begin
                    w_em     = 1'b1;
                    w_em_tok = mk_tok(w_kw, 8'h00, r_tstart);
                    n_hcnt   = 3'd0;
                    w_ret    = 1'b1;
                end else if (!r_forced && w_kwp) begin
                    // remaining letters stay held as a keyword prefix
                    w_ret = 1'b1;
                end else begin
                    w_em     = 1'b1;
                    w_em_tok = mk_tok(KIND_VAR, r_hb[0], r_tstart);
                    n_hb     = {8'h00, r_hb[HB_DEPTH-1:1]};
                    n_hcnt   = r_hcnt - 3'd1;
                    n_tstart = w_tstart_inc;
                end
            end
            P_FLUSH: begin
                if (r_num_active) begin
                    w_em         = 1'b1;
                    w_em_tok     = w_num_tok;
                    n_num_active = 1'b0;
                    n_num_sat    = 1'b0;
                    n_acc        = '0;
                end else if (r_hold_cmp) begin
                    w_em       = 1'b1;
                    w_em_tok   = mk_tok(KIND_OP, r_hb[0], r_tstart);
                    n_hold_cmp = 1'b0;
                end else if (r_hcnt != 3'd0) begin
                    n_forced = 1'b1;
                    n_ret    = RET_FLUSH;
                    n_phase  = P_RESOLVE;
                end else begin
                    n_phase = P_END;
                end
            end
            P_END: begin
                w_pop   = 1'b1;
                n_phase = P_HANDLE;
            end
            default: begin
                n_phase = P_HANDLE;
            end
        endcase

        if (w_ret) begin
            case (r_ret)
                RET_FRESH: n_phase = P_FRESH;
                RET_HDONE: w_hdone = 1'b1;
                RET_FLUSH: n_phase = P_FLUSH;
                default:   n_phase = P_FLUSH;
            endcase
        end

        // a character that starts a token on its own
        if (w_fresh) begin
            w_hdone = 1'b1;
            case (w_cls)
                CLS_SPACE: begin
                end
                CLS_DIGIT: begin
                    n_num_active = 1'b1;
                    n_num_sat    = 1'b0;
                    n_acc        = {{(INT_WIDTH-4){1'b0}}, w_c[3:0]};
                    n_tstart     = i_q_col;
                end
                CLS_KW_LETTER: begin
                    n_hb[0]  = w_c;
                    n_hcnt   = 3'd1;
                    n_tstart = i_q_col;
                end
                CLS_LETTER: begin
                    w_em     = 1'b1;
                    w_em_tok = mk_tok(KIND_VAR, w_c, i_q_col);
                end
                CLS_OP: begin
                    w_em     = 1'b1;
                    w_em_tok = mk_tok(KIND_OP, w_c, i_q_col);
                end
                CLS_LT, CLS_GT: begin
                    n_hb[0]    = w_c;
                    n_hold_cmp = 1'b1;
                    n_tstart   = i_q_col;
                end
                default: begin
                    w_em     = 1'b1;
                    w_em_tok = mk_tok(KIND_ERROR, w_c, i_q_col);
                end
            endcase
        end

        if (w_hdone) begin
            if (w_eol) begin
                n_phase = P_FLUSH;
            end else begin
                n_phase = P_HANDLE;
                w_pop   = 1'b1;
            end
        end
    end

    assign w_stall = (w_em && !w_can_emit) ||
                     ((r_phase == P_END) && r_pend_v && !w_out_free);
    assign o_q_pop = w_pop && !w_stall;

    // output register and held token
    always_comb begin
        n_out_v    = r_out_v && !i_m_tready;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        if (!w_stall) begin
            if (w_em) begin
                if (w_eol) begin
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                        n_out_v    = 1'b1;
                    end
                    n_pend   = w_em_tok;
                    n_pend_v = 1'b1;
                end else begin
                    n_out      = w_em_tok;
                    n_out_last = 1'b0;
                    n_out_v    = 1'b1;
                end
            end else if ((r_phase == P_END) && r_pend_v) begin
                n_out      = r_pend;
                n_out_last = 1'b1;
                n_out_v    = 1'b1;
                n_pend_v   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_HANDLE;
            r_hcnt       <= 3'd0;
            r_hold_cmp   <= 1'b0;
            r_num_active <= 1'b0;
            r_num_sat    <= 1'b0;
            r_acc        <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
            if (!w_stall) begin
                r_phase      <= n_phase;
                r_hcnt       <= n_hcnt;
                r_hold_cmp   <= n_hold_cmp;
                r_num_active <= n_num_active;
                r_num_sat    <= n_num_sat;
                r_acc        <= n_acc;
            end
        end
        if (!w_stall) begin
            r_ret    <= n_ret;
            r_forced <= n_forced;
            r_hb     <= n_hb;
            r_tstart <= n_tstart;
        end
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_v;
    assign o_token    = r_out;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_cmp_vs_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hold_cmp && (r_hcnt != 3'd0)))
        else $error("held operator and held letters at once");
    a_num_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num_active |-> (!r_hold_cmp && (r_hcnt == 3'd0)))
        else $error("integer in progress while a prefix is held");
    a_hold_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_HANDLE) |-> (r_hcnt <= 3'd5))
        else $error("held prefix longer than any keyword prefix");
    a_pend_in_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (i_q_valid && i_q_item.eol))
        else $error("held token outside an end of line step");
    a_busy_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != P_HANDLE) |-> i_q_valid)
        else $error("sequencer busy with no character at queue head");
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num_sat |-> (r_acc == '1))
        else $error("saturated integer not at full scale");
`endif

endmodule

`default_nettype wire

// ----- sim/basic_keyword_lexer_unit_test.sv -----
// self-checking testbench for basic_keyword_lexer_unit: drives source bytes on the slave
// side and checks every token against a behavioral lexer; depends on bklex_pkg and the rtl
`timescale 1ns / 1ps

module basic_keyword_lexer_unit_test;
    import bklex_pkg::*;

    localparam int QUIET_LIMIT = 3000;   // cycles with no request moving before giving up
    localparam int DRAIN_WAIT  = 40;     // extra wait after the last expected token
    localparam int RAND_ITEMS  = 480;
    localparam int LONG_LINE   = 270;    // longer than LINE_LEN so the column wraps

    // expected token, fields as the block reports them
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [15:0] value;
        logic        ovf;
        logic [7:0]  col;
        logic        last;
    } t_tok_exp;

    // one row of the directed table
    typedef struct {
        logic [7:0] ch;
        bit         eol;
        bit         typed;
        t_tok_exp   want;
    } t_row;

    typedef logic [7:0] t_run [6];
    typedef logic [7:0] t_text [$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;

    // lexer state kept by the testbench
    logic [7:0]  held [5];      // held letters, or a lone '<' / '>' in entry 0
    int          held_n;
    int unsigned num_val;
    bit          num_on;
    bit          num_sat;
    int          col_next;
    int          tok_col;

    t_tok_exp    step_out[$];        // tokens caused by the byte being predicted
    t_tok_exp    pending_tokens[$];  // tokens still owed by the block, oldest first
    t_row        table_rows[$];
    int          mismatches = 0;
    int          src_burst = 0;
    int          quiet = 0;

    basic_keyword_lexer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------------
    // behavioral lexer
    // ---------------------------------------------------------------------------------------

    function automatic int kw_length(t_kind k);
        case (k)
            KIND_IF:                      return 2;
            KIND_END, KIND_LET, KIND_REM: return 3;
            KIND_GOTO, KIND_THEN:         return 4;
            KIND_GOSUB:                   return 5;
            default:                      return 6;
        endcase
    endfunction

    // i-th letter of a keyword, counted from the left
    function automatic logic [7:0] kw_char(t_kind k, int i);
        logic [47:0] word;
        case (k)
            KIND_END:   word = "END";
            KIND_GOTO:  word = "GOTO";
            KIND_GOSUB: word = "GOSUB";
            KIND_IF:    word = "IF";
            KIND_LET:   word = "LET";
            KIND_REM:   word = "REM";
            KIND_RETURN: word = "RETURN";
            default:    word = "THEN";
        endcase
        return word[8 * (kw_length(k) - 1 - i) +: 8];
    endfunction

    // letters run[s .. s+n-1] spell the start of keyword k
    function automatic bit kw_fits(t_run run, int s, int n, t_kind k);
        if (kw_length(k) < n) return 1'b0;
        for (int i = 0; i < n; i++)
            if (run[s + i] != kw_char(k, i)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_op(logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "(", ")", CH_EQ, ",", CH_LF: return 1'b1;
            default:                                         return 1'b0;
        endcase
    endfunction

    function automatic void put_token(t_kind k, logic [7:0] c, int unsigned v, bit o, int col);
        t_tok_exp t;
        if (step_out.size() >= 8) return;
        t.kind  = k;
        t.ch    = c;
        t.value = v[15:0];
        t.ovf   = o;
        t.col   = 8'(col % BKL_LINE_LEN);
        t.last  = 1'b0;
        step_out.push_back(t);
    endfunction

    // resolve a run of adjacent letters: a whole keyword, a prefix worth holding,
    // or peel the first letter off as a variable and try again
    function automatic void settle_run(t_run run, int n, bit forced, int base);
        int s;
        bit pre;
        s = 0;
        if (n > 6) n = 6;
        held_n = 0;
        while (s < n) begin
            pre = 1'b0;
            for (int k = KIND_END; k <= KIND_THEN; k++) begin
                if (kw_length(t_kind'(k)) == n - s && kw_fits(run, s, n - s, t_kind'(k))) begin
                    put_token(t_kind'(k), 8'h00, 0, 1'b0, base);
                    return;
                end
                if (kw_length(t_kind'(k)) > n - s && kw_fits(run, s, n - s, t_kind'(k)))
                    pre = 1'b1;
            end
            if (!forced && pre && n - s <= 5) begin
                for (int i = 0; i < n - s; i++) held[i] = run[s + i];
                held_n  = n - s;
                tok_col = base % BKL_LINE_LEN;
                return;
            end
            put_token(KIND_VAR, run[s], 0, 1'b0, base);
            s++;
            base++;
        end
    endfunction

    function automatic void flush_number();
        put_token(KIND_INT, 8'h00, num_val, num_sat, tok_col);
        num_on  = 1'b0;
        num_sat = 1'b0;
        num_val = 0;
    endfunction

    // byte with nothing pending in front of it
    function automatic void start_char(logic [7:0] c, int col);
        t_run run;
        if (c == CH_SPACE || c == CH_TAB) return;
        if (is_digit(c)) begin
            num_on  = 1'b1;
            num_sat = 1'b0;
            num_val = c - "0";
            tok_col = col;
        end else if (is_upper(c)) begin
            run[0] = c;
            settle_run(run, 1, 1'b0, col);
        end else if (is_op(c)) begin
            put_token(KIND_OP, c, 0, 1'b0, col);
        end else if (c == CH_LT || c == CH_GT) begin
            held[0] = c;
            held_n  = 1;
            tok_col = col;
        end else begin
            put_token(KIND_ERROR, c, 0, 1'b0, col);
        end
    endfunction

    function automatic void next_char(logic [7:0] c, int col);
        t_run run;
        int unsigned v;
        logic [7:0] first;
        int n;
        if (num_on) begin
            if (is_digit(c)) begin
                v = num_val * 10 + (c - "0");
                if (v > (1 << BKL_INT_WIDTH) - 1) begin
                    num_val = (1 << BKL_INT_WIDTH) - 1;
                    num_sat = 1'b1;
                end else begin
                    num_val = v;
                end
                return;
            end
            flush_number();
        end
        if (held_n > 0 && (held[0] == CH_LT || held[0] == CH_GT)) begin
            first  = held[0];
            held_n = 0;
            if (c == CH_EQ) begin
                put_token(first == CH_LT ? KIND_LE : KIND_GE, 8'h00, 0, 1'b0, tok_col);
                return;
            end
            if ((first == CH_LT && c == CH_GT) || (first == CH_GT && c == CH_LT)) begin
                put_token(KIND_NE, 8'h00, 0, 1'b0, tok_col);
                return;
            end
            put_token(KIND_OP, first, 0, 1'b0, tok_col);
        end else if (held_n > 0) begin
            n = held_n;
            for (int i = 0; i < n; i++) run[i] = held[i];
            if (is_upper(c)) begin
                run[n] = c;
                settle_run(run, n + 1, 1'b0, tok_col);
                return;
            end
            settle_run(run, n, 1'b1, tok_col);
        end
        start_char(c, col);
    endfunction

    // end of line: everything pending goes out, keyword or not
    function automatic void flush_line();
        t_run run;
        if (num_on) flush_number();
        if (held_n > 0) begin
            if (held[0] == CH_LT || held[0] == CH_GT) begin
                put_token(KIND_OP, held[0], 0, 1'b0, tok_col);
            end else begin
                for (int i = 0; i < held_n; i++) run[i] = held[i];
                settle_run(run, held_n, 1'b1, tok_col);
            end
        end
        held_n = 0;
    endfunction

    // tokens caused by one accepted byte end up in step_out
    function automatic void lex_char(logic [7:0] c, bit eol);
        int col;
        t_tok_exp t;
        col = col_next % BKL_LINE_LEN;
        step_out.delete();
        next_char(c, col);
        if (eol) begin
            flush_line();
            if (step_out.size() > 0) begin
                t = step_out.pop_back();
                t.last = 1'b1;
                step_out.push_back(t);
            end
            col_next = 0;
        end else begin
            col_next = (col + 1) % BKL_LINE_LEN;
        end
    endfunction

    // ---------------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------------

    // idle cycles before the next request, with occasional stretches of none at all
    function automatic int next_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void plain_row(logic [7:0] c, bit eol);
        t_row r;
        r.ch    = c;
        r.eol   = eol;
        r.typed = 1'b0;
        r.want  = '0;
        table_rows.push_back(r);
    endfunction

    // row whose single token is written out by hand
    function automatic void typed_row(logic [7:0] c, bit eol, t_kind k, logic [7:0] tc,
                                      logic [15:0] v, bit o, logic [7:0] col, bit last);
        t_row r;
        r.ch    = c;
        r.eol   = eol;
        r.typed = 1'b1;
        r.want  = '{kind: k, ch: tc, value: v, ovf: o, col: col, last: last};
        table_rows.push_back(r);
    endfunction

    // one line of source made of mostly well-formed tokens, some broken ones and noise
    function automatic t_text make_line(int min_len);
        t_text line;
        logic [71:0] op_set;
        t_kind k;
        int pieces;
        int n;
        op_set = "+-*/()=,\n";
        pieces = $urandom_range(1, 8);
        while (pieces > 0 || line.size() < min_len) begin
            k = t_kind'($urandom_range(KIND_END, KIND_THEN));
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int i = 0; i < kw_length(k); i++) line.push_back(kw_char(k, i));
                end
                2: begin
                    // keyword that falls apart part way
                    n = $urandom_range(1, kw_length(k) - 1);
                    for (int i = 0; i < n; i++) line.push_back(kw_char(k, i));
                    if ($urandom_range(0, 1)) line.push_back(8'($urandom_range("A", "Z")));
                end
                3: begin
                    // keyword glued to a following letter or digit
                    for (int i = 0; i < kw_length(k); i++) line.push_back(kw_char(k, i));
                    if ($urandom_range(0, 1)) line.push_back(8'($urandom_range("A", "Z")));
                    else line.push_back(8'($urandom_range("0", "9")));
                end
                4: line.push_back(8'($urandom_range("A", "Z")));
                5, 6: begin
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) line.push_back(8'($urandom_range("0", "9")));
                end
                7: line.push_back(op_set[8 * $urandom_range(0, 8) +: 8]);
                8: begin
                    line.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
                    case ($urandom_range(0, 3))
                        0: line.push_back(CH_EQ);
                        1: line.push_back(CH_LT);
                        2: line.push_back(CH_GT);
                        default: ;
                    endcase
                end
                default: begin
                    if ($urandom_range(0, 2) != 0) line.push_back(8'($urandom_range(0, 255)));
                    else line.push_back(CH_TAB);
                end
            endcase
            if ($urandom_range(0, 1)) line.push_back(CH_SPACE);
            pieces--;
        end
        return line;
    endfunction

    // one byte request on the slave side; its tokens are queued once it is taken
    task automatic send_char(logic [7:0] c, bit eol, bit typed, t_tok_exp want);
        int gap;
        gap = next_wait(src_burst);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eol;
        do @(posedge i_clk); while (!o_s_tready);
        lex_char(c, eol);
        if (typed) pending_tokens.push_back(want);
        else foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
    endtask

    // ---------------------------------------------------------------------------------------
    // token side: random back pressure and checking
    // ---------------------------------------------------------------------------------------

    initial begin : token_sink
        int stall;
        int burst;
        burst = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = next_wait(burst);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : token_check
        t_token   got;
        t_tok_exp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_token'(o_m_tdata[36:0]);
            if (pending_tokens.size() == 0) begin
                $display("%0t: token with nothing expected, tdata %h tlast %b",
                         $time, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", want.kind, got.kind);
                check_field("token_char", want.ch, got.ch);
                check_field("int_value", want.value, got.value);
                check_field("int_overflow", want.ovf, got.ovf);
                check_field("start_column", want.col, got.col);
                check_field("last_of_line", want.last, o_m_tlast);
            end
        end
    end

    // watchdog: no request moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no request moved for %0d cycles, %0d tokens outstanding",
                     $time, quiet, pending_tokens.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------------

    initial begin : stimulus
        t_text line;
        int    done_items;
        bit    long_done;
        held     = '{default: 8'h00};
        held_n   = 0;
        num_val  = 0;
        num_on   = 1'b0;
        num_sat  = 1'b0;
        col_next = 0;
        tok_col  = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // NUL and 0xff are both error bytes, each with its column
        typed_row(8'h00, 1'b0, KIND_ERROR, 8'h00, 16'h0000, 1'b0, 8'd0, 1'b0);
        typed_row(8'hFF, 1'b1, KIND_ERROR, 8'hFF, 16'h0000, 1'b0, 8'd1, 1'b1);
        // 99999 saturates and is flushed by the end of line
        plain_row("9", 1'b0);
        plain_row("9", 1'b0);
        plain_row("9", 1'b0);
        plain_row("9", 1'b0);
        typed_row("9", 1'b1, KIND_INT, 8'h00, 16'hFFFF, 1'b1, 8'd0, 1'b1);
        // <> then >= then a lone < left at line end
        plain_row(CH_LT, 1'b0);
        typed_row(CH_GT, 1'b0, KIND_NE, 8'h00, 16'h0000, 1'b0, 8'd0, 1'b0);
        plain_row(CH_GT, 1'b0);
        typed_row(CH_EQ, 1'b0, KIND_GE, 8'h00, 16'h0000, 1'b0, 8'd2, 1'b0);
        typed_row(CH_LT, 1'b1, KIND_OP, CH_LT, 16'h0000, 1'b0, 8'd4, 1'b1);
        // GOSUB completes, then a variable on the end-of-line byte
        plain_row("G", 1'b0);
        plain_row("O", 1'b0);
        plain_row("S", 1'b0);
        plain_row("U", 1'b0);
        typed_row("B", 1'b0, KIND_GOSUB, 8'h00, 16'h0000, 1'b0, 8'd0, 1'b0);
        typed_row("Z", 1'b1, KIND_VAR, "Z", 16'h0000, 1'b0, 8'd5, 1'b1);
        // RET fails on X and is rescanned into four variables; the tab ends the line
        // without a token of its own, so nothing carries tlast
        plain_row("R", 1'b0);
        plain_row("E", 1'b0);
        plain_row("T", 1'b0);
        plain_row("X", 1'b0);
        plain_row(CH_TAB, 1'b1);
        // keyword complete on the last byte of the line
        plain_row("I", 1'b0);
        typed_row("F", 1'b1, KIND_IF, 8'h00, 16'h0000, 1'b0, 8'd0, 1'b1);
        // unfinished keyword at line end falls back to variables
        plain_row("T", 1'b0);
        plain_row("H", 1'b1);
        // newline is an ordinary operator
        typed_row(CH_LF, 1'b1, KIND_OP, CH_LF, 16'h0000, 1'b0, 8'd0, 1'b1);

        foreach (table_rows[i])
            send_char(table_rows[i].ch, table_rows[i].eol, table_rows[i].typed,
                      table_rows[i].want);

        // random lines; one of them is long enough to wrap the column counter
        done_items = 0;
        long_done  = 1'b0;
        while (done_items < RAND_ITEMS) begin
            line = make_line((!long_done && done_items > RAND_ITEMS / 2) ? LONG_LINE : 0);
            if (line.size() >= LONG_LINE) long_done = 1'b1;
            foreach (line[i]) begin
                send_char(line[i], i == line.size() - 1, 1'b0, '0);
                done_items++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
